// ===== rtl/core/point_in_polygon_test_top_macros.svh =====
// Assertion macros for the point-in-polygon test block.
// Used by pip_cell.sv under rtl/core; assertions drop out under SYNTHESIS.
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PIP_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pip assertion failed");
// next-cycle implication
`define PIP_ASSERT_NX(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pip assertion failed");
`else
`define PIP_ASSERT(label, clk, rst_n, ante, cons)
`define PIP_ASSERT_NX(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pip_pkg.sv =====
// Shared constants and types for the point-in-polygon test block.
// No dependencies; used by every module in rtl/core.
package pip_pkg;

	localparam int MAX_VERTICES    = 6;
	localparam int COORD_FRAC_BITS = 4;

	localparam int VERTEX_REGS = 6;
	localparam int NUM_CELLS   = (MAX_VERTICES < VERTEX_REGS) ? MAX_VERTICES : VERTEX_REGS;
	localparam int CELL_W      = $clog2(VERTEX_REGS);

	localparam int PNT_W   = 16;
	localparam int COORD_W = 20;
	localparam int VTX_W   = 2 * COORD_W;
	localparam int VCNT_W  = 3;
	localparam int PT_W    = PNT_W + COORD_FRAC_BITS;
	localparam int CMP_W   = ((PT_W > COORD_W) ? PT_W : COORD_W) + 1;
	localparam int PROD_W  = 2 * CMP_W;

	// register map
	localparam int CFG_IDX_W        = 3;
	localparam int REG_VERTEX_COUNT = 0;
	localparam int REG_VERTEX_A     = 1;
	localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(4);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CMP_W-1:0]   cmp_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		logic signed [PNT_W-1:0] point_x;
		logic signed [PNT_W-1:0] point_y;
		logic                    flag;
	} word_t;

	// one polygon edge: vertex i and its predecessor j
	typedef struct packed {
		coord_t xi;
		coord_t yi;
		coord_t xj;
		coord_t yj;
		logic   en;
	} seg_t;

endpackage

// ===== rtl/core/pip_cfg_regs.sv =====
// Vertex count and vertex registers, and the edge list handed to the cells.
// Depends on pip_pkg.
module pip_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pip_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pip_pkg::VTX_W-1:0]       cfg_data,
	output pip_pkg::seg_t                   segs [pip_pkg::NUM_CELLS]
);

	logic [pip_pkg::VCNT_W-1:0] vcnt_q;
	logic [pip_pkg::VTX_W-1:0]  vtx_q [pip_pkg::VERTEX_REGS];
	logic [pip_pkg::VCNT_W-1:0] n_eff;
	logic [pip_pkg::CELL_W-1:0] last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= pip_pkg::VCNT_RESET;
			for (int k = 0; k < pip_pkg::VERTEX_REGS; k++) begin
				vtx_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == pip_pkg::CFG_IDX_W'(pip_pkg::REG_VERTEX_COUNT)) begin
				vcnt_q <= cfg_data[pip_pkg::VCNT_W-1:0];
			end
			for (int k = 0; k < pip_pkg::VERTEX_REGS; k++) begin
				if (cfg_index == pip_pkg::CFG_IDX_W'(pip_pkg::REG_VERTEX_A + k)) begin
					vtx_q[k] <= cfg_data;
				end
			end
		end
	end

	// count clamps to the number of cells; edge 0 closes on the last vertex in use
	always_comb begin
		if (vcnt_q > pip_pkg::VCNT_W'(pip_pkg::NUM_CELLS)) begin
			n_eff = pip_pkg::VCNT_W'(pip_pkg::NUM_CELLS);
		end else begin
			n_eff = vcnt_q;
		end
		if (n_eff == '0) begin
			last_idx = '0;
		end else begin
			last_idx = pip_pkg::CELL_W'(n_eff - pip_pkg::VCNT_W'(1));
		end
	end

	always_comb begin
		for (int k = 0; k < pip_pkg::NUM_CELLS; k++) begin
			segs[k].xi = vtx_q[k][pip_pkg::VTX_W-1:pip_pkg::COORD_W];
			segs[k].yi = vtx_q[k][pip_pkg::COORD_W-1:0];
			if (k == 0) begin
				segs[k].xj = vtx_q[last_idx][pip_pkg::VTX_W-1:pip_pkg::COORD_W];
				segs[k].yj = vtx_q[last_idx][pip_pkg::COORD_W-1:0];
			end else begin
				segs[k].xj = vtx_q[k-1][pip_pkg::VTX_W-1:pip_pkg::COORD_W];
				segs[k].yj = vtx_q[k-1][pip_pkg::COORD_W-1:0];
			end
			segs[k].en = (pip_pkg::VCNT_W'(k) < n_eff);
		end
	end

endmodule

// ===== rtl/core/pip_cell.sv =====
// One edge cell: cross-multiply in the first stage, compare and toggle in the second.
// Depends on pip_pkg and point_in_polygon_test_top_macros.svh.
`include "point_in_polygon_test_top_macros.svh"
module pip_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  pip_pkg::seg_t  seg,
	input  logic           up_valid,
	input  pip_pkg::word_t up_word,
	output logic           up_stall,
	output logic           dn_valid,
	output pip_pkg::word_t dn_word,
	input  logic           dn_stall
);

	logic           vld_s1, vld_s2;
	pip_pkg::word_t word_s1, word_s2;
	pip_pkg::prod_t lhs_s1, rhs_s1;
	logic           hit_s1, dypos_s1;
	logic           adv1, adv2;

	pip_pkg::cmp_t  px_e, py_e, xi_e, yi_e, xj_e, yj_e, dy;
	pip_pkg::prod_t lhs, rhs;
	logic           hit, left;

	assign adv2     = !vld_s2 || !dn_stall;
	assign adv1     = !vld_s1 || adv2;
	assign up_stall = !adv1;
	assign dn_valid = vld_s2;
	assign dn_word  = word_s2;

	always_comb begin
		px_e = pip_pkg::cmp_t'(up_word.point_x) <<< pip_pkg::COORD_FRAC_BITS;
		py_e = pip_pkg::cmp_t'(up_word.point_y) <<< pip_pkg::COORD_FRAC_BITS;
		xi_e = pip_pkg::cmp_t'(seg.xi);
		yi_e = pip_pkg::cmp_t'(seg.yi);
		xj_e = pip_pkg::cmp_t'(seg.xj);
		yj_e = pip_pkg::cmp_t'(seg.yj);
		dy   = yj_e - yi_e;
		hit  = seg.en && ((yi_e > py_e) != (yj_e > py_e));
		// sign of dy decides the direction of the left-of compare
		lhs  = pip_pkg::prod_t'(pip_pkg::cmp_t'(px_e - xi_e)) * pip_pkg::prod_t'(dy);
		rhs  = pip_pkg::prod_t'(pip_pkg::cmp_t'(xj_e - xi_e))
			* pip_pkg::prod_t'(pip_pkg::cmp_t'(py_e - yi_e));
	end

	assign left = dypos_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= up_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && up_valid) begin
			word_s1  <= up_word;
			lhs_s1   <= lhs;
			rhs_s1   <= rhs;
			hit_s1   <= hit;
			dypos_s1 <= (dy > pip_pkg::cmp_t'(0));
		end
		if (adv2 && vld_s1) begin
			word_s2.point_x <= word_s1.point_x;
			word_s2.point_y <= word_s1.point_y;
			word_s2.flag    <= word_s1.flag ^ (hit_s1 && left);
		end
	end

	`PIP_ASSERT(a_empty_no_stall, clk, arst_n, !vld_s1, !up_stall)
	`PIP_ASSERT_NX(a_s1_hold, clk, arst_n, vld_s1 && !adv2,
		vld_s1 && $stable(word_s1) && $stable(lhs_s1) && $stable(rhs_s1))
	`PIP_ASSERT_NX(a_s2_hold, clk, arst_n, vld_s2 && dn_stall, vld_s2 && $stable(word_s2))
	`PIP_ASSERT_NX(a_s2_fill, clk, arst_n, vld_s1 && adv2, vld_s2)

endmodule

// ===== rtl/core/point_in_polygon_test_top.sv =====
// Point-in-polygon test, top level: vertex registers and the chain of edge cells.
// Depends on pip_pkg, pip_cfg_regs and pip_cell.
//
// Takes one integer point per cycle while in_stall is low and returns one even-odd inside
// flag per point, in order. Each polygon edge has its own two-register cell (multiply,
// then compare and toggle), and the sustained rate is one point per clock while
// out_stall stays low; the last cell's second register is the output register.
// Vertex registers may be written only while no point is in flight.
module point_in_polygon_test_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pip_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pip_pkg::VTX_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [pip_pkg::PNT_W-1:0] point_x,
	input  logic signed [pip_pkg::PNT_W-1:0] point_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            inside_res
);

	pip_pkg::seg_t  segs  [pip_pkg::NUM_CELLS];
	pip_pkg::word_t words [pip_pkg::NUM_CELLS+1];
	logic           vlds  [pip_pkg::NUM_CELLS+1];
	logic           stls  [pip_pkg::NUM_CELLS+1];

	pip_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.segs      (segs)
	);

	assign words[0].point_x = point_x;
	assign words[0].point_y = point_y;
	assign words[0].flag    = 1'b0;
	assign vlds[0]          = in_valid;
	assign in_stall         = stls[0];

	for (genvar k = 0; k < pip_pkg::NUM_CELLS; k++) begin : g_cell
		pip_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.seg      (segs[k]),
			.up_valid (vlds[k]),
			.up_word  (words[k]),
			.up_stall (stls[k]),
			.dn_valid (vlds[k+1]),
			.dn_word  (words[k+1]),
			.dn_stall (stls[k+1])
		);
	end

	assign stls[pip_pkg::NUM_CELLS] = out_stall;
	assign out_valid                = vlds[pip_pkg::NUM_CELLS];
	assign inside_res               = words[pip_pkg::NUM_CELLS].flag;

endmodule
